@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lcabl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lcabl_pkg;

	localparam int NODE_W  = 10;
	localparam int NODES   = 1 << NODE_W;
	localparam int DEPTH_W = 11;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_INS_D  = 11'b000_0000_0010,
		ST_INS_L  = 11'b000_0000_0100,
		ST_Q_DX   = 11'b000_0000_1000,
		ST_Q_DY   = 11'b000_0001_0000,
		ST_LIFT   = 11'b000_0010_0000,
		ST_LIFT_W = 11'b000_0100_0000,
		ST_DOWN_B = 11'b000_1000_0000,
		ST_DOWN_C = 11'b001_0000_0000,
		ST_LCA_W  = 11'b010_0000_0000,
		ST_DIST   = 11'b100_0000_0000
	} state_t;

endpackage
`default_nettype wire

@@ rtl/lcabl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcabl_ram #(
	parameter int W     = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_q;
	logic [W-1:0] wd_q;
	logic         fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
		wd_q <= wdata;
	end

	// forward a write that lands on the entry read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? wd_q : rd_q;

endmodule
`default_nettype wire

@@ rtl/lca_binary_lifting_top.sv @@
// Insert: writes the depth and level-0 ancestor, then one ancestor level per step; no result beat.
// Query: reads both depths, lifts the deeper node by the depth difference, then walks down the
// levels to the common ancestor, skipping the descent when one node lies above the other,
// using one ancestor-memory read port walked once per level in each pass.
// One item in flight; the next input is taken while a result beat waits.
// Reset (async, active low) clears control and output valid; node 0 reads as zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lca_binary_lifting_top #(
	parameter int LEVELS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        action,
	input  wire logic [lcabl_pkg::NODE_W-1:0]  node_x,
	input  wire logic [lcabl_pkg::NODE_W-1:0]  node_y,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [lcabl_pkg::NODE_W-1:0]  ancestor,
	output logic      [lcabl_pkg::DEPTH_W-1:0] distance
);

	localparam int NW    = lcabl_pkg::NODE_W;
	localparam int DW    = lcabl_pkg::DEPTH_W;
	localparam int ADEP  = lcabl_pkg::NODES * LEVELS;
	localparam int AW    = $clog2(ADEP);
	localparam int LCW   = $clog2(LEVELS + 1);
	localparam logic [LCW-1:0] LVL_TOP = LCW'(LEVELS - 1);
	localparam logic [LCW-1:0] LVL_END = LCW'(LEVELS);

	function automatic logic [AW-1:0] anc_addr(input logic [NW-1:0] node,
		input logic [LCW-1:0] lvl);
		anc_addr = AW'(node) * AW'(LEVELS) + AW'(lvl);
	endfunction

	lcabl_pkg::state_t state_q;
	logic [NW-1:0]  a_q, b_q, ua_q, lca_q;
	logic [DW-1:0]  dx_q, dy_q, diff_q;
	logic [LCW-1:0] lvl_q;
	logic           out_valid_q;
	logic [NW-1:0]  ancestor_q;
	logic [DW-1:0]  distance_q;
	logic           anc_zero_q, dep_zero_q;

	logic           anc_we, dep_we;
	logic [NW-1:0]  anc_rnode, anc_wnode, anc_wdata, dep_raddr;
	logic [LCW-1:0] anc_rlvl, anc_wlvl;
	logic [DW-1:0]  dep_wdata;
	logic [NW-1:0]  anc_rd, anc_d;
	logic [DW-1:0]  dep_rd, dep_d, dep_inc, diff_sh;
	logic [NW-1:0]  na, nb;
	logic           out_free;
	logic signed [DW+2:0] dist_raw;
	logic [DW-1:0]  dist_sat;

	lcabl_ram #(.W(NW), .DEPTH(ADEP)) u_anc_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (anc_we),
		.waddr (anc_addr(anc_wnode, anc_wlvl)),
		.wdata (anc_wdata),
		.raddr (anc_addr(anc_rnode, anc_rlvl)),
		.rdata (anc_rd)
	);

	lcabl_ram #(.W(DW), .DEPTH(lcabl_pkg::NODES)) u_dep_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (dep_we),
		.waddr (a_q),
		.wdata (dep_wdata),
		.raddr (dep_raddr),
		.rdata (dep_rd)
	);

	assign anc_d    = anc_zero_q ? '0 : anc_rd;
	assign dep_d    = dep_zero_q ? '0 : dep_rd;
	assign dep_inc  = (dep_d == lcabl_pkg::DEPTH_MAX) ? dep_d : dep_d + DW'(1);
	assign diff_sh  = diff_q >> lvl_q;
	assign na       = (ua_q != anc_d) ? ua_q  : a_q;
	assign nb       = (ua_q != anc_d) ? anc_d : b_q;
	assign out_free = !out_valid_q || out_ready;
	assign dist_raw = $signed({3'b000, dx_q}) + $signed({3'b000, dy_q})
		- $signed({2'b00, dep_d, 1'b0});
	assign dist_sat = (dist_raw < 0) ? '0 :
		(dist_raw > $signed({3'b000, lcabl_pkg::DEPTH_MAX})) ? lcabl_pkg::DEPTH_MAX :
		dist_raw[DW-1:0];

	assign in_ready  = (state_q == lcabl_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;
	assign distance  = distance_q;

	always_comb begin
		anc_we    = 1'b0;
		anc_wnode = a_q;
		anc_wlvl  = lvl_q;
		anc_wdata = anc_d;
		anc_rnode = b_q;
		anc_rlvl  = lvl_q;
		dep_we    = 1'b0;
		dep_wdata = dep_inc;
		dep_raddr = lca_q;
		case (state_q)
			lcabl_pkg::ST_IDLE: begin
				dep_raddr = (action == lcabl_pkg::ACT_QUERY) ? node_x : node_y;
			end
			lcabl_pkg::ST_INS_D: begin
				dep_we    = 1'b1;
				anc_we    = 1'b1;
				anc_wlvl  = '0;
				anc_wdata = b_q;
				anc_rlvl  = '0;
			end
			lcabl_pkg::ST_INS_L: begin
				anc_we    = 1'b1;
				anc_rnode = anc_d;
			end
			lcabl_pkg::ST_Q_DX: begin
				dep_raddr = b_q;
			end
			lcabl_pkg::ST_LIFT: begin
				if (lvl_q == LVL_END) begin
					anc_rnode = a_q;
					anc_rlvl  = LVL_TOP;
					dep_raddr = a_q;
				end
			end
			lcabl_pkg::ST_DOWN_C: begin
				anc_rnode = na;
				anc_rlvl  = (lvl_q == '0) ? '0 : lvl_q - LCW'(1);
			end
			lcabl_pkg::ST_LCA_W: begin
				dep_raddr = anc_d;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lcabl_pkg::ST_IDLE: begin
				a_q <= node_x;
				b_q <= node_y;
			end
			lcabl_pkg::ST_INS_L: begin
				lvl_q <= lvl_q + LCW'(1);
			end
			lcabl_pkg::ST_INS_D: begin
				lvl_q <= LCW'(1);
			end
			lcabl_pkg::ST_Q_DX: begin
				dx_q <= dep_d;
			end
			lcabl_pkg::ST_Q_DY: begin
				dy_q  <= dep_d;
				lvl_q <= '0;
				if (dep_d < dx_q) begin
					a_q    <= b_q;
					b_q    <= a_q;
					diff_q <= dx_q - dep_d;
				end else begin
					diff_q <= dep_d - dx_q;
				end
			end
			lcabl_pkg::ST_LIFT: begin
				if (lvl_q == LVL_END) begin
					lca_q <= a_q;
					lvl_q <= LVL_TOP;
				end else if (!diff_sh[0]) begin
					lvl_q <= lvl_q + LCW'(1);
				end
			end
			lcabl_pkg::ST_LIFT_W: begin
				b_q   <= anc_d;
				lvl_q <= lvl_q + LCW'(1);
			end
			lcabl_pkg::ST_DOWN_B: begin
				ua_q <= anc_d;
			end
			lcabl_pkg::ST_DOWN_C: begin
				a_q <= na;
				b_q <= nb;
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LCW'(1);
				end
			end
			lcabl_pkg::ST_LCA_W: begin
				lca_q <= anc_d;
			end
			lcabl_pkg::ST_DIST: begin
				if (out_free) begin
					ancestor_q <= lca_q;
					distance_q <= dist_sat;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcabl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			anc_zero_q  <= 1'b1;
			dep_zero_q  <= 1'b1;
		end else begin
			anc_zero_q <= (anc_rnode == '0);
			dep_zero_q <= (dep_raddr == '0);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lcabl_pkg::ST_IDLE: begin
					if (in_valid) begin
						if (action == lcabl_pkg::ACT_QUERY) begin
							state_q <= lcabl_pkg::ST_Q_DX;
						end else if (node_x != '0) begin
							state_q <= lcabl_pkg::ST_INS_D;
						end
					end
				end
				lcabl_pkg::ST_INS_D: begin
					state_q <= (LEVELS == 1) ? lcabl_pkg::ST_IDLE : lcabl_pkg::ST_INS_L;
				end
				lcabl_pkg::ST_INS_L: begin
					if (lvl_q == LVL_TOP) begin
						state_q <= lcabl_pkg::ST_IDLE;
					end
				end
				lcabl_pkg::ST_Q_DX: begin
					state_q <= lcabl_pkg::ST_Q_DY;
				end
				lcabl_pkg::ST_Q_DY: begin
					state_q <= lcabl_pkg::ST_LIFT;
				end
				lcabl_pkg::ST_LIFT: begin
					if (lvl_q == LVL_END) begin
						state_q <= (a_q == b_q) ? lcabl_pkg::ST_DIST : lcabl_pkg::ST_DOWN_B;
					end else if (diff_sh[0]) begin
						state_q <= lcabl_pkg::ST_LIFT_W;
					end
				end
				lcabl_pkg::ST_LIFT_W: begin
					state_q <= lcabl_pkg::ST_LIFT;
				end
				lcabl_pkg::ST_DOWN_B: begin
					state_q <= lcabl_pkg::ST_DOWN_C;
				end
				lcabl_pkg::ST_DOWN_C: begin
					state_q <= (lvl_q == '0) ? lcabl_pkg::ST_LCA_W : lcabl_pkg::ST_DOWN_B;
				end
				lcabl_pkg::ST_LCA_W: begin
					state_q <= lcabl_pkg::ST_DIST;
				end
				lcabl_pkg::ST_DIST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= lcabl_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lcabl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_sentinel_write, clk, arst_n, anc_we, anc_wnode != '0, "sentinel row written")
	`ASSERT_IMPLY(a_depth_write_state, clk, arst_n, dep_we, state_q == lcabl_pkg::ST_INS_D, "stray depth write")
	`ASSERT_IMPLY(a_down_level, clk, arst_n, (state_q == lcabl_pkg::ST_DOWN_B) || (state_q == lcabl_pkg::ST_DOWN_C), lvl_q < LVL_END, "level out of range")
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, (state_q == lcabl_pkg::ST_DIST) && out_free, out_valid_q, "result beat lost")

endmodule
`default_nettype wire

@@ dv/lca_binary_lifting_checker.sv @@
`timescale 1ns / 1ps
module lca_binary_lifting_checker #(
	parameter int LEVELS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic              action,
	input  wire lcabl_pkg::node_t  node_x,
	input  wire lcabl_pkg::node_t  node_y,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire lcabl_pkg::node_t  ancestor,
	input  wire lcabl_pkg::depth_t distance,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		lcabl_pkg::node_t  anc;
		lcabl_pkg::depth_t path_len;
	} lca_answer_t;

	lcabl_pkg::node_t  jump_tbl [lcabl_pkg::NODES][LEVELS];
	lcabl_pkg::depth_t level_tbl [lcabl_pkg::NODES];
	lca_answer_t       answer_q [$];

	function automatic void hang_node(lcabl_pkg::node_t child, lcabl_pkg::node_t parent);
		int unsigned d;
		int          j;
		if (child == '0)
			return;
		d = level_tbl[parent] + 1;
		if (d > lcabl_pkg::DEPTH_MAX)
			d = lcabl_pkg::DEPTH_MAX;
		level_tbl[child] = lcabl_pkg::depth_t'(d);
		jump_tbl[child][0] = parent;
		for (j = 1; j < LEVELS; j++)
			jump_tbl[child][j] = jump_tbl[jump_tbl[child][j-1]][j-1];
	endfunction

	function automatic lca_answer_t lift_query(lcabl_pkg::node_t x, lcabl_pkg::node_t y);
		lcabl_pkg::node_t lo;
		lcabl_pkg::node_t hi;
		lcabl_pkg::node_t ua;
		lcabl_pkg::node_t ub;
		lcabl_pkg::node_t meet;
		int unsigned      diff;
		int               span;
		int               j;
		lca_answer_t      r;
		lo = x;
		hi = y;
		if (level_tbl[y] < level_tbl[x]) begin
			lo = y;
			hi = x;
		end
		diff = level_tbl[hi] - level_tbl[lo];
		for (j = 0; j < LEVELS; j++)
			if (diff[j])
				hi = jump_tbl[hi][j];
		if (lo == hi) begin
			meet = lo;
		end else begin
			for (j = LEVELS - 1; j >= 0; j--) begin
				ua = jump_tbl[lo][j];
				ub = jump_tbl[hi][j];
				if (ua != ub) begin
					lo = ua;
					hi = ub;
				end
			end
			meet = jump_tbl[lo][0];
		end
		span = int'(level_tbl[x]) + int'(level_tbl[y]) - 2 * int'(level_tbl[meet]);
		if (span < 0)
			span = 0;
		if (span > int'(lcabl_pkg::DEPTH_MAX))
			span = int'(lcabl_pkg::DEPTH_MAX);
		r.anc      = meet;
		r.path_len = lcabl_pkg::depth_t'(span);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lca_answer_t want;
		if (!arst_n) begin
			for (int j = 0; j < LEVELS; j++)
				jump_tbl[0][j] = '0;
			level_tbl[0] = '0;
			answer_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					errors++;
					$error("result beat with no query outstanding: ancestor %0d distance %0d",
						ancestor, distance);
				end else begin
					want = answer_q.pop_front();
					if (ancestor !== want.anc) begin
						errors++;
						$error("ancestor: expected %0d, actual %0d", want.anc, ancestor);
					end
					if (distance !== want.path_len) begin
						errors++;
						$error("distance: expected %0d, actual %0d", want.path_len, distance);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action == lcabl_pkg::ACT_QUERY)
					answer_q.push_back(lift_query(node_x, node_y));
				else
					hang_node(node_x, node_y);
			end
			pending <= answer_q.size();
		end
	end

endmodule

@@ dv/tb_lca_binary_lifting_top.sv @@
`timescale 1ns / 1ps
module tb_lca_binary_lifting_top;

	localparam int LEVELS        = 10;
	localparam int RANDOM_ITEMS  = 700;
	localparam int CHAIN_INSERTS = 1040;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 80;
	localparam int STALL_LIMIT   = 3000;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              action    = lcabl_pkg::ACT_INSERT;
	lcabl_pkg::node_t  node_x    = '0;
	lcabl_pkg::node_t  node_y    = '0;
	logic              out_ready = 1'b0;
	logic              in_ready;
	logic              out_valid;
	lcabl_pkg::node_t  ancestor;
	lcabl_pkg::depth_t distance;
	int                errors;
	int                pending;

	bit                known [lcabl_pkg::NODES];
	lcabl_pkg::node_t  known_q [$];
	lcabl_pkg::node_t  last_child = '0;
	bit                tx_quiet   = 1'b0;
	bit                rx_quiet   = 1'b0;
	bit                hold_req   = 1'b0;
	int                n_ins      = 0;
	int                n_qry      = 0;
	int                n_drop     = 0;
	int                idle_cycles = 0;

	lca_binary_lifting_top #(
		.LEVELS(LEVELS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.node_x   (node_x),
		.node_y   (node_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ancestor (ancestor),
		.distance (distance)
	);

	lca_binary_lifting_checker #(
		.LEVELS(LEVELS)
	) u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.node_x   (node_x),
		.node_y   (node_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ancestor (ancestor),
		.distance (distance),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lcabl_pkg::node_t pick_known();
		return known_q[$urandom_range(0, known_q.size() - 1)];
	endfunction

	function automatic lcabl_pkg::node_t pick_fresh();
		lcabl_pkg::node_t c;
		do
			c = lcabl_pkg::node_t'($urandom_range(1, lcabl_pkg::NODES - 1));
		while (known[c] && known_q.size() < lcabl_pkg::NODES);
		return c;
	endfunction

	task automatic send(input logic act, input lcabl_pkg::node_t x, input lcabl_pkg::node_t y);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		node_x   <= x;
		node_y   <= y;
		do @(posedge clk); while (!in_ready);
		if (act == lcabl_pkg::ACT_QUERY) begin
			n_qry++;
		end else if (x == '0) begin
			n_drop++;
		end else begin
			n_ins++;
			if (!known[x]) begin
				known[x] = 1'b1;
				known_q.push_back(x);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic random_item();
		lcabl_pkg::node_t child;
		lcabl_pkg::node_t parent;
		int               r;
		if (known_q.size() < 40 || $urandom_range(0, 99) < 45) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				child = '0;
			else if (r < 20)
				child = pick_known();
			else
				child = pick_fresh();
			parent = ($urandom_range(0, 99) < 35) ? last_child : pick_known();
			send(lcabl_pkg::ACT_INSERT, child, parent);
			if (child != '0)
				last_child = child;
		end else if ($urandom_range(0, 99) < 30) begin
			send(lcabl_pkg::ACT_QUERY, last_child, pick_known());
		end else begin
			send(lcabl_pkg::ACT_QUERY, pick_known(), pick_known());
		end
	endtask

	initial begin
		lcabl_pkg::node_t deep;
		lcabl_pkg::node_t z;
		lcabl_pkg::node_t w1;
		lcabl_pkg::node_t w2;
		known[0] = 1'b1;
		known_q.push_back('0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(lcabl_pkg::ACT_INSERT, 10'd1, 10'd0);
		send(lcabl_pkg::ACT_INSERT, 10'd1023, 10'd1);
		send(lcabl_pkg::ACT_INSERT, 10'd512, 10'd1023);
		send(lcabl_pkg::ACT_INSERT, 10'd0, 10'd512);
		send(lcabl_pkg::ACT_INSERT, 10'd682, 10'd1023);
		send(lcabl_pkg::ACT_INSERT, 10'd341, 10'd682);
		send(lcabl_pkg::ACT_INSERT, 10'd2, 10'd1);
		send(lcabl_pkg::ACT_INSERT, 10'd3, 10'd2);
		send(lcabl_pkg::ACT_QUERY, 10'd0, 10'd0);
		send(lcabl_pkg::ACT_QUERY, 10'd1023, 10'd512);
		send(lcabl_pkg::ACT_QUERY, 10'd512, 10'd1023);
		send(lcabl_pkg::ACT_QUERY, 10'd1, 10'd1);
		send(lcabl_pkg::ACT_QUERY, 10'd512, 10'd0);
		send(lcabl_pkg::ACT_QUERY, 10'd0, 10'd341);
		send(lcabl_pkg::ACT_QUERY, 10'd341, 10'd3);
		send(lcabl_pkg::ACT_QUERY, 10'd3, 10'd341);
		send(lcabl_pkg::ACT_QUERY, 10'd512, 10'd341);
		send(lcabl_pkg::ACT_QUERY, 10'd1023, 10'd1023);
		send(lcabl_pkg::ACT_QUERY, 10'd682, 10'd512);
		last_child = 10'd3;

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 150 == 0)
				tx_quiet = ($urandom_range(0, 3) == 0);
			if (k == 200) begin
				// stall the output side and keep offering queries back to back
				hold_req = 1'b1;
				tx_quiet = 1'b1;
				repeat (24) send(lcabl_pkg::ACT_QUERY, pick_known(), pick_known());
				tx_quiet = 1'b0;
			end
			if (k == 350) begin
				drain();
				// drive one node past the lifting span by hanging it under itself
				deep = pick_fresh();
				send(lcabl_pkg::ACT_INSERT, deep, pick_known());
				repeat (CHAIN_INSERTS) send(lcabl_pkg::ACT_INSERT, deep, deep);
				z  = pick_fresh();
				send(lcabl_pkg::ACT_INSERT, z, 10'd0);
				w1 = pick_fresh();
				send(lcabl_pkg::ACT_INSERT, w1, z);
				w2 = pick_fresh();
				send(lcabl_pkg::ACT_INSERT, w2, z);
				send(lcabl_pkg::ACT_INSERT, z, deep);
				send(lcabl_pkg::ACT_QUERY, w1, w2);
				send(lcabl_pkg::ACT_QUERY, w1, z);
				send(lcabl_pkg::ACT_QUERY, deep, 10'd0);
				send(lcabl_pkg::ACT_QUERY, deep, deep);
				send(lcabl_pkg::ACT_QUERY, 10'd1, deep);
			end
			if (k == 550)
				drain();
			random_item();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d inserts, %0d sentinel inserts and %0d LCA queries on a %0d-node tree,",
			n_ins, n_drop, n_qry, known_q.size());
		$display("with a %0d-deep self-insert chain and a %0d-cycle output stall.",
			CHAIN_INSERTS, HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		int gap;
		int beats;
		beats = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (beats % 120 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_quiet ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			beats++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
